FILE: rtl/modular_inverse_ext_euclid_unit_defines.svh
// Assertion helpers shared by the modular inverse unit.
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EEU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define EEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/eeu_pkg.sv
package eeu_pkg;

   // Port field width and default datapath width
   localparam int FIELD_W       = 63;
   localparam int WIDTH_DEFAULT = 64;

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic [FIELD_W-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] inverse;
      logic [FIELD_W-1:0] common_divisor;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIVIDE,
      S_UPDATE,
      S_FOLD
   } state_type;

endpackage

FILE: rtl/modular_inverse_ext_euclid_unit.sv
// Modular inverse by the extended Euclidean algorithm. Pulse start while busy is
// low to transfer one request; busy then stays high until the result appears.
// Each Euclid iteration is a zero check, the shared bit-serial divide step over
// the WIDTH-1 dividend bits (which also accumulates minus the quotient times the
// coefficient), and an update. An item needs at most about 1.44*(WIDTH-1)
// iterations plus a final check, fold and output; a zero modulus skips the
// divide and goes from the check to the fold. The result is shown
// on rsp_data for exactly one cycle with rsp_valid high and cannot be held off,
// so the receiver must capture it in that cycle. When the gcd is not one,
// inverse is the folded final coefficient and carries no meaning as an inverse.
`include "modular_inverse_ext_euclid_unit_defines.svh"

module modular_inverse_ext_euclid_unit #(
   parameter int WIDTH = eeu_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  eeu_pkg::req_type req_data,
   output logic             rsp_valid,
   output eeu_pkg::rsp_type rsp_data
);
   import eeu_pkg::*;

   localparam int OperW = WIDTH - 1;
   localparam int CntW  = $clog2(OperW);

   state_type         state_ff, state_in;
   logic [OperW-1:0]  r0_ff, r0_in;
   logic [OperW-1:0]  r1_ff, r1_in;
   logic [OperW-1:0]  mod_ff, mod_in;
   logic [WIDTH-1:0]  x0_ff, x0_in;
   logic [WIDTH-1:0]  x1_ff, x1_in;
   logic [OperW-1:0]  dvd_ff, dvd_in;
   logic [OperW-1:0]  rem_ff, rem_in;
   logic [WIDTH-1:0]  acc_ff, acc_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [OperW-1:0]  step_rem;
   logic [WIDTH-1:0]  step_acc;
   logic [WIDTH-1:0]  fold;

   // Shared divide and coefficient step
   eeu_div_step #(
      .WIDTH(WIDTH)
   ) u_step (
      .rem_i        (rem_ff),
      .dividend_bit (dvd_ff[OperW-1]),
      .divisor      (r1_ff),
      .acc_i        (acc_ff),
      .coeff        (x1_ff),
      .rem_o        (step_rem),
      .acc_o        (step_acc)
   );

   // Fold a negative coefficient into range
   always_comb begin
      fold = x0_ff[WIDTH-1] ? (x0_ff + {1'b0, mod_ff}) : x0_ff;
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      mod_in       = mod_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               r0_in    = req_data.value[OperW-1:0];
               r1_in    = req_data.modulus[OperW-1:0];
               mod_in   = req_data.modulus[OperW-1:0];
               x0_in    = WIDTH'(1);
               x1_in    = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (r1_ff == '0) begin
               state_in = S_FOLD;
            end else begin
               dvd_in   = r0_ff;
               rem_in   = '0;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            rem_in = step_rem;
            acc_in = step_acc;
            dvd_in = {dvd_ff[OperW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(OperW - 1)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            r0_in    = r1_ff;
            r1_in    = rem_ff;
            x0_in    = x1_ff;
            x1_in    = x0_ff + acc_ff;
            state_in = S_CHECK;
         end
         S_FOLD: begin
            rsp_in.inverse        = FIELD_W'(fold[OperW-1:0]);
            rsp_in.common_divisor = FIELD_W'(r0_ff);
            rsp_valid_in          = 1'b1;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      mod_ff <= mod_in;
      x0_ff  <= x0_in;
      x1_ff  <= x1_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `EEU_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid,
      "result strobe lasted more than one cycle")
   `EEU_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy,
      "transfer did not raise busy")
   `EEU_ASSERT_NOW(a_idle_on_result, clock, reset, rsp_valid, !busy,
      "result shown while still busy")
   `EEU_ASSERT_NOW(a_rem_below_divisor, clock, reset, state_ff == S_DIVIDE,
      rem_ff < r1_ff, "partial remainder reached divisor")

endmodule

FILE: rtl/eeu_div_step.sv
module eeu_div_step #(
   parameter int WIDTH = eeu_pkg::WIDTH_DEFAULT
) (
   input  logic [WIDTH-2:0] rem_i,
   input  logic             dividend_bit,
   input  logic [WIDTH-2:0] divisor,
   input  logic [WIDTH-1:0] acc_i,
   input  logic [WIDTH-1:0] coeff,
   output logic [WIDTH-2:0] rem_o,
   output logic [WIDTH-1:0] acc_o
);
   import eeu_pkg::*;

   localparam int OperW = WIDTH - 1;

   logic [OperW:0] shifted;
   logic [OperW:0] diff;
   logic           quot_bit;

   // One restoring division step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted  = {rem_i, dividend_bit};
      diff     = shifted - {1'b0, divisor};
      quot_bit = (shifted >= {1'b0, divisor});
      rem_o    = quot_bit ? diff[OperW-1:0] : shifted[OperW-1:0];
   end

   // Horner accumulation of -q*coeff, quotient bits arrive MSB first
   always_comb begin
      acc_o = {acc_i[WIDTH-2:0], 1'b0} - (quot_bit ? coeff : '0);
   end

endmodule
